// ===== hdl/spq_pkg.sv =====
package spq_pkg;

    localparam int IdW  = 16;
    localparam int PriW = 8;

    localparam logic [1:0] KIND_INSERT = 2'd0;
    localparam logic [1:0] KIND_POP    = 2'd1;
    localparam logic [1:0] KIND_SEARCH = 2'd2;
    localparam logic [1:0] KIND_LIST   = 2'd3;

    localparam logic [2:0] ST_INSERTED  = 3'd0;
    localparam logic [2:0] ST_POPPED    = 3'd1;
    localparam logic [2:0] ST_FOUND     = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND = 3'd3;
    localparam logic [2:0] ST_EMPTY     = 3'd4;
    localparam logic [2:0] ST_FULL      = 3'd5;
    localparam logic [2:0] ST_LIST      = 3'd6;

    typedef struct packed {
        logic [1:0]      kind;
        logic [IdW-1:0]  patient_id;
        logic [PriW-1:0] priority_req;
    } t_in;

    typedef struct packed {
        logic [2:0]      status;
        logic [IdW-1:0]  out_id;
        logic [PriW-1:0] out_priority;
        logic            last;
    } t_out;

    typedef struct packed {
        logic            valid;
        logic [IdW-1:0]  id;
        logic [PriW-1:0] pri;
    } t_entry;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_INSERT,
        OP_ADVANCE
    } t_op;

endpackage

// ===== hdl/spq_cell.sv =====
module spq_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  spq_pkg::t_op    i_op,
    input  spq_pkg::t_entry i_new,
    input  spq_pkg::t_entry i_left,
    input  logic            i_left_shift,
    input  spq_pkg::t_entry i_right,
    output spq_pkg::t_entry o_entry,
    output logic            o_shift
);
    import spq_pkg::*;

    t_entry r_entry;
    t_entry n_entry;

    // entry moves toward the tail when the new item outranks it
    assign o_shift = r_entry.valid && (r_entry.pri < i_new.pri);
    assign o_entry = r_entry;

    always_comb begin
        n_entry = r_entry;
        case (i_op)
            OP_INSERT: begin
                if (i_left_shift) begin
                    n_entry = i_left;
                end else if (o_shift || (!r_entry.valid && i_left.valid)) begin
                    n_entry = i_new;
                end
            end
            OP_ADVANCE: begin
                n_entry = i_right;
            end
            default: begin
                n_entry = r_entry;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry.valid <= 1'b0;
        end else begin
            r_entry.valid <= n_entry.valid;
        end
        r_entry.id  <= n_entry.id;
        r_entry.pri <= n_entry.pri;
    end

endmodule

// ===== hdl/stable_priority_queue.sv =====
// Insert and pop: an accepted beat's result is registered into the output register;
// one item per cycle while the output is taken. An empty-queue list answers like a pop.
// Search and non-empty list: the cell chain rotates once through all DEPTH cells, so no
// new beat is taken until the rotation ends (the rotation pauses while the output stalls);
// list emits one beat per cycle while the output is taken, head first.
// Reset (synchronous, active low) empties the queue and the output register.
module stable_priority_queue #(
    parameter int DEPTH = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  spq_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output spq_pkg::t_out o_out_data
);
    import spq_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = $clog2(DEPTH);

    typedef enum logic {
        S_IDLE,
        S_ROT
    } t_state;

    t_state         r_state,  n_state;
    logic [SW-1:0]  r_step,   n_step;
    logic [IdW-1:0] r_key,    n_key;
    logic           r_is_list, n_is_list;
    logic           r_found,  n_found;
    logic [CW-1:0]  r_count,  n_count;
    logic           r_ovalid, n_ovalid;
    t_out           r_odata,  n_odata;

    t_op    w_op;
    t_entry w_new;
    t_entry w_tail;
    t_entry w_head;
    t_entry w_entry [DEPTH];
    logic   w_shift [DEPTH];
    logic   w_out_free;
    logic   w_accept;
    logic   w_match;
    logic   w_last_step;

    assign w_new      = '{valid: 1'b1, id: i_in_data.patient_id, pri: i_in_data.priority_req};
    assign w_head     = w_entry[0];
    assign w_tail     = (r_state == S_ROT) ? w_head : '0;
    assign w_out_free = !r_ovalid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE) && w_out_free;
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_match    = w_head.valid && (w_head.id == r_key);
    assign w_last_step = (r_step == SW'(DEPTH - 1));

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        t_entry w_left;
        t_entry w_right;
        logic   w_left_shift;
        if (g == 0) begin : g_first
            assign w_left       = '{valid: 1'b1, id: '0, pri: '0};
            assign w_left_shift = 1'b0;
        end else begin : g_mid
            assign w_left       = w_entry[g-1];
            assign w_left_shift = w_shift[g-1];
        end
        if (g == DEPTH - 1) begin : g_last
            assign w_right = w_tail;
        end else begin : g_inner
            assign w_right = w_entry[g+1];
        end
        spq_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_op         (w_op),
            .i_new        (w_new),
            .i_left       (w_left),
            .i_left_shift (w_left_shift),
            .i_right      (w_right),
            .o_entry      (w_entry[g]),
            .o_shift      (w_shift[g])
        );
    end

    always_comb begin
        n_state   = r_state;
        n_step    = r_step;
        n_key     = r_key;
        n_is_list = r_is_list;
        n_found   = r_found;
        n_count   = r_count;
        n_ovalid  = r_ovalid && !i_out_ready;
        n_odata   = r_odata;
        w_op      = OP_HOLD;

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_ovalid = 1'b1;
                    n_odata  = '{status: ST_EMPTY, out_id: '0, out_priority: '0, last: 1'b1};
                    case (i_in_data.kind)
                        KIND_INSERT: begin
                            n_odata.out_id       = i_in_data.patient_id;
                            n_odata.out_priority = i_in_data.priority_req;
                            if (r_count == CW'(DEPTH)) begin
                                n_odata.status = ST_FULL;
                            end else begin
                                n_odata.status = ST_INSERTED;
                                w_op           = OP_INSERT;
                                n_count        = r_count + 1'b1;
                            end
                        end
                        KIND_POP: begin
                            if (r_count != '0) begin
                                n_odata.status       = ST_POPPED;
                                n_odata.out_id       = w_head.id;
                                n_odata.out_priority = w_head.pri;
                                w_op                 = OP_ADVANCE;
                                n_count              = r_count - 1'b1;
                            end
                        end
                        KIND_SEARCH: begin
                            n_ovalid  = r_ovalid && !i_out_ready;
                            n_odata   = r_odata;
                            n_key     = i_in_data.patient_id;
                            n_found   = 1'b0;
                            n_is_list = 1'b0;
                            n_step    = '0;
                            n_state   = S_ROT;
                        end
                        KIND_LIST: begin
                            if (r_count != '0) begin
                                n_ovalid  = r_ovalid && !i_out_ready;
                                n_odata   = r_odata;
                                n_is_list = 1'b1;
                                n_step    = '0;
                                n_state   = S_ROT;
                            end
                        end
                        default: begin
                            n_ovalid = r_ovalid && !i_out_ready;
                        end
                    endcase
                end
            end
            S_ROT: begin
                if (w_out_free) begin
                    w_op   = OP_ADVANCE;
                    n_step = r_step + 1'b1;
                    if (w_last_step) begin
                        n_state = S_IDLE;
                    end
                    if (r_is_list) begin
                        if (w_head.valid) begin
                            n_ovalid = 1'b1;
                            n_odata  = '{status: ST_LIST, out_id: w_head.id,
                                         out_priority: w_head.pri,
                                         last: (CW'(r_step) + 1'b1 == r_count)};
                        end
                    end else if (!r_found) begin
                        if (w_match) begin
                            n_ovalid = 1'b1;
                            n_found  = 1'b1;
                            n_odata  = '{status: ST_FOUND, out_id: w_head.id,
                                         out_priority: w_head.pri, last: 1'b1};
                        end else if (w_last_step) begin
                            n_ovalid = 1'b1;
                            n_odata  = '{status: ST_NOT_FOUND, out_id: r_key,
                                         out_priority: '0, last: 1'b1};
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_ovalid <= n_ovalid;
        end
        r_step    <= n_step;
        r_key     <= n_key;
        r_is_list <= n_is_list;
        r_found   <= n_found;
        r_odata   <= n_odata;
    end

    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_odata;

endmodule
